// ===== src/c8_pkg.sv =====
// shared constants, types and font table of the chip-8 core
package c8_pkg;

	localparam int MEM_DEPTH   = 4096;
	localparam int AW          = $clog2(MEM_DEPTH);
	localparam int SCREEN_W    = 64;
	localparam int SCREEN_H    = 32;
	localparam int ROW_W       = $clog2(SCREEN_H);
	localparam int PX_W        = $clog2(SCREEN_W);
	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int SD_W        = $clog2(STACK_DEPTH + 1);
	localparam int NREG        = 16;
	localparam int GLYPH_N     = 80;

	localparam logic [AW-1:0] RESET_PC   = 12'd512;
	localparam logic [AW-1:0] RESET_FONT = 12'd80;

	// host operations
	typedef enum logic [2:0] {
		FN_WRITE   = 3'd0,
		FN_READ    = 3'd1,
		FN_ROW     = 3'd2,
		FN_EXEC    = 3'd3,
		FN_TICK    = 3'd4,
		FN_RESTART = 3'd5
	} func_t;

	// configuration register indexes
	localparam logic CFG_START = 1'b0;
	localparam logic CFG_FONT  = 1'b1;

	// instruction groups (top nibble)
	localparam logic [3:0] OPG_SYS  = 4'h0;
	localparam logic [3:0] OPG_JP   = 4'h1;
	localparam logic [3:0] OPG_CALL = 4'h2;
	localparam logic [3:0] OPG_SEI  = 4'h3;
	localparam logic [3:0] OPG_SNEI = 4'h4;
	localparam logic [3:0] OPG_SER  = 4'h5;
	localparam logic [3:0] OPG_LDI  = 4'h6;
	localparam logic [3:0] OPG_ADDI = 4'h7;
	localparam logic [3:0] OPG_ALU  = 4'h8;
	localparam logic [3:0] OPG_SNER = 4'h9;
	localparam logic [3:0] OPG_SETI = 4'hA;
	localparam logic [3:0] OPG_JPV0 = 4'hB;
	localparam logic [3:0] OPG_RND  = 4'hC;
	localparam logic [3:0] OPG_DRW  = 4'hD;
	localparam logic [3:0] OPG_KEY  = 4'hE;
	localparam logic [3:0] OPG_MISC = 4'hF;

	// register-register operations
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [7:0] KEY_DOWN   = 8'h9E;
	localparam logic [7:0] KEY_UP     = 8'hA1;
	localparam logic [7:0] F_GET_DT   = 8'h07;
	localparam logic [7:0] F_WAIT_KEY = 8'h0A;
	localparam logic [7:0] F_SET_DT   = 8'h15;
	localparam logic [7:0] F_SET_ST   = 8'h18;
	localparam logic [7:0] F_ADD_I    = 8'h1E;
	localparam logic [7:0] F_GLYPH    = 8'h29;
	localparam logic [7:0] F_BCD      = 8'h33;
	localparam logic [7:0] F_STORE    = 8'h55;
	localparam logic [7:0] F_LOAD     = 8'h65;

	localparam logic [3:0] REG_V0 = 4'h0;
	localparam logic [3:0] REG_VF = 4'hF;

	localparam logic [7:0] GLYPHS [GLYPH_N] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	// reset content of main memory at one address
	function automatic logic [7:0] init_byte(input logic [AW-1:0] a);
		logic [AW-1:0] off;
		off = a - RESET_FONT;
		if (a >= RESET_FONT && off < AW'(GLYPH_N))
			return GLYPHS[off[6:0]];
		return 8'h00;
	endfunction

endpackage

// ===== src/c8_ram.sv =====
// generic single-write, single-read synchronous ram
module c8_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== src/chip8_cpu_core.sv =====
// chip-8 core: sequencer around main memory, display, register file and stack rams
// steps: each item passes dispatch and done, a read adds a ram read; execute fetches
//   two bytes, reads vx, vy, v0, executes, then a flag write or return, a read and write
//   per sprite row plus a last read, per register for block moves, or bcd digit writes;
//   one item at a time, the next is taken the cycle after the result is registered
// reset: a clearing pass over main memory loads the font and zeroes the rest;
//   no item is taken until it ends, configuration writes are taken throughout
module chip8_cpu_core
	import c8_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic          cfg_index,
	input  logic [11:0]   cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [2:0]    func,
	input  logic [11:0]   address,
	input  logic [7:0]    data,
	input  logic [15:0]   keys,
	input  logic [7:0]    random_byte,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [63:0]   read_data,
	output logic [11:0]   program_counter,
	output logic          sound_on,
	output logic          waiting_key,
	output logic          stack_error
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DISP, S_RD, S_ROW, S_F1, S_F2, S_VY, S_V0, S_EXEC,
		S_VF, S_RET, S_DRD, S_DWR, S_BCD, S_SRD, S_SWR, S_LRD, S_LWR, S_DONE
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	func_t               func_q;
	logic [AW-1:0]       addr_q;
	logic [7:0]          data_q;
	logic [15:0]         keys_q;
	logic [7:0]          rnd_q;
	logic [AW-1:0]       start_q, font_q, pc_q, idx_q;
	logic [SD_W-1:0]     depth_q;
	logic [7:0]          dt_q, st_q;
	logic [15:0]         prev_q;
	logic [7:0]          hi_q;
	logic [15:0]         op_q;
	logic [7:0]          vx_q, vy_q, v0_q;
	logic [3:0]          cnt_q;
	logic                hit_q, flag_q;
	logic [PX_W-1:0]     px_q;
	logic [ROW_W-1:0]    py_q;
	logic [63:0]         rd_q;
	logic                wait_q, serr_q;
	logic [SCREEN_H-1:0] dv_q;
	logic [NREG-1:0]     rv_q;
	logic [3:0]          rf_ra_q;
	logic                out_valid_q, out_snd_q, out_wait_q, out_serr_q;
	logic [63:0]         out_rd_q;
	logic [AW-1:0]       out_pc_q;

	// ram ports
	logic            mem_we;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [7:0]      mem_wdata, mem_rdata;
	logic            disp_we;
	logic [ROW_W-1:0] disp_waddr, disp_raddr;
	logic [63:0]     disp_wdata, disp_rdata;
	logic            rf_we;
	logic [3:0]      rf_waddr, rf_raddr;
	logic [7:0]      rf_wdata, rf_rdata;
	logic            stk_we;
	logic [SP_W-1:0] stk_waddr, stk_raddr;
	logic [AW-1:0]   stk_rdata;

	c8_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);
	c8_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_disp (
		.clk(clk), .we(disp_we), .waddr(disp_waddr), .wdata(disp_wdata),
		.raddr(disp_raddr), .rdata(disp_rdata)
	);
	c8_ram #(.WIDTH(8), .DEPTH(NREG)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);
	c8_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(pc_q + AW'(2)),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	// instruction fields
	logic [3:0]    op_x, op_y, op_n, op_grp;
	logic [7:0]    op_nn;
	logic [AW-1:0] op_nnn, pc_inc, pc_skip, mem_ptr;
	assign op_grp  = op_q[15:12];
	assign op_x    = op_q[11:8];
	assign op_y    = op_q[7:4];
	assign op_n    = op_q[3:0];
	assign op_nn   = op_q[7:0];
	assign op_nnn  = op_q[11:0];
	assign pc_inc  = pc_q + AW'(2);
	assign pc_skip = pc_q + AW'(4);
	assign mem_ptr = idx_q + AW'(cnt_q);

	// register file entries never written read as zero
	logic [7:0] rf_val;
	assign rf_val = rv_q[rf_ra_q] ? rf_rdata : 8'h00;

	// sprite row under draw, clipped at the bottom edge
	logic [ROW_W:0]   row_sum;
	logic [ROW_W-1:0] row;
	logic             row_end;
	logic [63:0]      spr, old_row;
	assign row_sum = {1'b0, py_q} + (ROW_W+1)'(cnt_q);
	assign row     = row_sum[ROW_W-1:0];
	assign row_end = (cnt_q == op_n) || row_sum[ROW_W];
	assign spr     = {mem_rdata, 56'd0} >> px_q;
	assign old_row = dv_q[row] ? disp_rdata : 64'd0;

	// key wait: lowest key released since the previous item
	logic [15:0] rel;
	logic [3:0]  key_k;
	assign rel = prev_q & ~keys_q;
	always_comb begin
		key_k = 4'd0;
		for (int i = 15; i >= 0; i--)
			if (rel[i])
				key_k = 4'(i);
	end

	// decimal digits of vx, tens by reciprocal multiply
	logic [1:0]  bcd_h;
	logic [7:0]  bcd_rem8;
	logic [14:0] bcd_prod;
	logic [3:0]  bcd_t;
	logic [6:0]  bcd_o7;
	logic [7:0]  bcd_dig;
	assign bcd_h    = (vx_q >= 8'd200) ? 2'd2 : (vx_q >= 8'd100) ? 2'd1 : 2'd0;
	assign bcd_rem8 = vx_q - ((vx_q >= 8'd200) ? 8'd200 : (vx_q >= 8'd100) ? 8'd100 : 8'd0);
	assign bcd_prod = 15'(bcd_rem8[6:0]) * 15'd205;
	assign bcd_t    = bcd_prod[14:11];
	assign bcd_o7   = bcd_rem8[6:0] - 7'({bcd_t, 3'b000}) - 7'({bcd_t, 1'b0});
	always_comb begin
		unique case (cnt_q)
			4'd0:    bcd_dig = 8'(bcd_h);
			4'd1:    bcd_dig = 8'(bcd_t);
			default: bcd_dig = 8'(bcd_o7[3:0]);
		endcase
	end

	// register writes of the execute step
	logic [8:0] sum9;
	logic       ex_wr, ex_vf, ex_flag;
	logic [7:0] ex_val;
	assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};
	always_comb begin
		ex_wr   = 1'b0;
		ex_vf   = 1'b0;
		ex_flag = 1'b0;
		ex_val  = vx_q;
		case (op_grp)
			OPG_LDI:  begin ex_wr = 1'b1; ex_val = op_nn; end
			OPG_ADDI: begin ex_wr = 1'b1; ex_val = vx_q + op_nn; end
			OPG_RND:  begin ex_wr = 1'b1; ex_val = rnd_q & op_nn; end
			OPG_ALU: begin
				case (op_n)
					ALU_MOV: begin ex_wr = 1'b1; ex_val = vy_q; end
					ALU_OR:  begin ex_wr = 1'b1; ex_val = vx_q | vy_q; end
					ALU_AND: begin ex_wr = 1'b1; ex_val = vx_q & vy_q; end
					ALU_XOR: begin ex_wr = 1'b1; ex_val = vx_q ^ vy_q; end
					ALU_ADD: begin
						ex_wr = 1'b1; ex_vf = 1'b1;
						ex_val = sum9[7:0]; ex_flag = sum9[8];
					end
					ALU_SUB: begin
						ex_wr = 1'b1; ex_vf = 1'b1;
						ex_val = vx_q - vy_q; ex_flag = (vx_q >= vy_q);
					end
					ALU_SHR: begin
						ex_wr = 1'b1; ex_vf = 1'b1;
						ex_val = {1'b0, vx_q[7:1]}; ex_flag = vx_q[0];
					end
					ALU_SUBN: begin
						ex_wr = 1'b1; ex_vf = 1'b1;
						ex_val = vy_q - vx_q; ex_flag = (vy_q >= vx_q);
					end
					ALU_SHL: begin
						ex_wr = 1'b1; ex_vf = 1'b1;
						ex_val = {vx_q[6:0], 1'b0}; ex_flag = vx_q[7];
					end
					default: ;
				endcase
			end
			OPG_MISC: begin
				if (op_nn == F_GET_DT) begin
					ex_wr = 1'b1; ex_val = dt_q;
				end else if (op_nn == F_WAIT_KEY && rel != 16'd0) begin
					ex_wr = 1'b1; ex_val = 8'(key_k);
				end
			end
			default: ;
		endcase
	end

	logic call_ok, ret_ok;
	assign call_ok = (depth_q < SD_W'(STACK_DEPTH));
	assign ret_ok  = (depth_q != '0);

	// ram port steering
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = mem_ptr;
		mem_wdata  = rf_val;
		mem_raddr  = pc_q;
		disp_we    = 1'b0;
		disp_waddr = row;
		disp_wdata = old_row ^ spr;
		disp_raddr = row;
		rf_we      = 1'b0;
		rf_waddr   = op_x;
		rf_wdata   = ex_val;
		rf_raddr   = REG_V0;
		stk_we     = 1'b0;
		stk_waddr  = depth_q[SP_W-1:0];
		stk_raddr  = SP_W'(depth_q - SD_W'(1));
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = init_byte(clr_q);
			end
			S_DISP: begin
				disp_raddr = addr_q[ROW_W-1:0];
				if (func_q == FN_WRITE) begin
					mem_we    = 1'b1;
					mem_waddr = addr_q;
					mem_wdata = data_q;
				end else if (func_q == FN_READ) begin
					mem_raddr = addr_q;
				end
			end
			S_F1: begin
				mem_raddr = pc_q + AW'(1);
				rf_raddr  = mem_rdata[3:0];
			end
			S_F2:  rf_raddr = mem_rdata[7:4];
			S_EXEC: begin
				rf_we  = ex_wr;
				stk_we = (op_grp == OPG_CALL) && call_ok;
			end
			S_VF: begin
				rf_we    = 1'b1;
				rf_waddr = REG_VF;
				rf_wdata = {7'd0, flag_q};
			end
			S_DRD: begin
				mem_raddr = mem_ptr;
				if (row_end) begin
					rf_we    = 1'b1;
					rf_waddr = REG_VF;
					rf_wdata = {7'd0, hit_q};
				end
			end
			S_DWR: disp_we = 1'b1;
			S_BCD: begin
				mem_we    = 1'b1;
				mem_wdata = bcd_dig;
			end
			S_SRD: rf_raddr = cnt_q;
			S_SWR: mem_we = 1'b1;
			S_LRD: mem_raddr = mem_ptr;
			S_LWR: begin
				rf_we    = 1'b1;
				rf_waddr = cnt_q;
				rf_wdata = mem_rdata;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			func_q      <= FN_WRITE;
			addr_q      <= '0;
			data_q      <= '0;
			keys_q      <= '0;
			rnd_q       <= '0;
			start_q     <= RESET_PC;
			font_q      <= RESET_FONT;
			pc_q        <= RESET_PC;
			idx_q       <= '0;
			depth_q     <= '0;
			dt_q        <= '0;
			st_q        <= '0;
			prev_q      <= '0;
			hi_q        <= '0;
			op_q        <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			v0_q        <= '0;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			flag_q      <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			rd_q        <= '0;
			wait_q      <= 1'b0;
			serr_q      <= 1'b0;
			dv_q        <= '0;
			rv_q        <= '0;
			rf_ra_q     <= '0;
			out_valid_q <= 1'b0;
			out_rd_q    <= '0;
			out_pc_q    <= '0;
			out_snd_q   <= 1'b0;
			out_wait_q  <= 1'b0;
			out_serr_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_START: start_q <= cfg_data;
					CFG_FONT:  font_q  <= cfg_data;
				endcase
			end
			// the done state refills the output register itself
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			if (disp_we)
				dv_q[disp_waddr] <= 1'b1;
			if (rf_we)
				rv_q[rf_waddr] <= 1'b1;
			rf_ra_q <= rf_raddr;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MEM_DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func_t'(func);
						addr_q  <= address;
						data_q  <= data;
						keys_q  <= keys;
						rnd_q   <= random_byte;
						rd_q    <= '0;
						wait_q  <= 1'b0;
						serr_q  <= 1'b0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_DONE;
					case (func_q)
						FN_READ: state_q <= S_RD;
						FN_ROW: if (addr_q < AW'(SCREEN_H)) state_q <= S_ROW;
						FN_EXEC: state_q <= S_F1;
						FN_TICK: begin
							if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
							if (st_q != 8'd0) st_q <= st_q - 8'd1;
						end
						FN_RESTART: begin
							pc_q    <= start_q;
							depth_q <= '0;
						end
						default: ;
					endcase
				end
				S_RD: begin
					rd_q    <= {56'd0, mem_rdata};
					state_q <= S_DONE;
				end
				S_ROW: begin
					rd_q    <= dv_q[addr_q[ROW_W-1:0]] ? disp_rdata : 64'd0;
					state_q <= S_DONE;
				end
				S_F1: begin
					hi_q    <= mem_rdata;
					state_q <= S_F2;
				end
				S_F2: begin
					op_q    <= {hi_q, mem_rdata};
					vx_q    <= rf_val;
					state_q <= S_VY;
				end
				S_VY: begin
					vy_q    <= rf_val;
					state_q <= S_V0;
				end
				S_V0: begin
					v0_q    <= rf_val;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					pc_q    <= pc_inc;
					state_q <= ex_vf ? S_VF : S_DONE;
					flag_q  <= ex_flag;
					cnt_q   <= '0;
					case (op_grp)
						OPG_SYS: begin
							if (op_q == OP_CLS) begin
								dv_q <= '0;
							end else if (op_q == OP_RET) begin
								if (ret_ok) begin
									depth_q <= depth_q - SD_W'(1);
									state_q <= S_RET;
								end else begin
									serr_q <= 1'b1;
								end
							end
						end
						OPG_JP: pc_q <= op_nnn;
						OPG_CALL: begin
							if (call_ok) begin
								depth_q <= depth_q + SD_W'(1);
								pc_q    <= op_nnn;
							end else begin
								serr_q <= 1'b1;
							end
						end
						OPG_SEI:  if (vx_q == op_nn) pc_q <= pc_skip;
						OPG_SNEI: if (vx_q != op_nn) pc_q <= pc_skip;
						OPG_SER:  if (op_n == 4'd0 && vx_q == vy_q) pc_q <= pc_skip;
						OPG_SNER: if (op_n == 4'd0 && vx_q != vy_q) pc_q <= pc_skip;
						OPG_SETI: idx_q <= op_nnn;
						OPG_JPV0: pc_q <= op_nnn + AW'(v0_q);
						OPG_DRW: begin
							hit_q   <= 1'b0;
							px_q    <= vx_q[PX_W-1:0];
							py_q    <= vy_q[ROW_W-1:0];
							state_q <= S_DRD;
						end
						OPG_KEY: begin
							if (op_nn == KEY_DOWN && keys_q[vx_q[3:0]])
								pc_q <= pc_skip;
							else if (op_nn == KEY_UP && !keys_q[vx_q[3:0]])
								pc_q <= pc_skip;
						end
						OPG_MISC: begin
							case (op_nn)
								F_WAIT_KEY: begin
									if (rel == 16'd0) begin
										pc_q   <= pc_q;
										wait_q <= 1'b1;
									end
								end
								F_SET_DT: dt_q <= vx_q;
								F_SET_ST: st_q <= vx_q;
								F_ADD_I:  idx_q <= idx_q + AW'(vx_q);
								F_GLYPH:  idx_q <= font_q + AW'({vx_q[3:0], 2'b00})
									+ AW'(vx_q[3:0]);
								F_BCD:    state_q <= S_BCD;
								F_STORE:  state_q <= S_SRD;
								F_LOAD:   state_q <= S_LRD;
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				S_VF:  state_q <= S_DONE;
				S_RET: begin
					pc_q    <= stk_rdata;
					state_q <= S_DONE;
				end
				S_DRD: state_q <= row_end ? S_DONE : S_DWR;
				S_DWR: begin
					if ((old_row & spr) != 64'd0)
						hit_q <= 1'b1;
					cnt_q   <= cnt_q + 4'd1;
					state_q <= S_DRD;
				end
				S_BCD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd2)
						state_q <= S_DONE;
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					cnt_q   <= cnt_q + 4'd1;
					state_q <= (cnt_q == op_x) ? S_DONE : S_SRD;
				end
				S_LRD: state_q <= S_LWR;
				S_LWR: begin
					cnt_q   <= cnt_q + 4'd1;
					state_q <= (cnt_q == op_x) ? S_DONE : S_LRD;
				end
				S_DONE: begin
					// hold the finished item until the output register frees up
					if (!(out_valid_q && out_stall)) begin
						out_valid_q <= 1'b1;
						out_rd_q    <= rd_q;
						out_pc_q    <= pc_q;
						out_snd_q   <= (st_q != 8'd0);
						out_wait_q  <= wait_q;
						out_serr_q  <= serr_q;
						prev_q      <= keys_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign read_data       = out_rd_q;
	assign program_counter = out_pc_q;
	assign sound_on        = out_snd_q;
	assign waiting_key     = out_wait_q;
	assign stack_error     = out_serr_q;

	// stack never holds more than its capacity
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= SD_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	// no item is taken during the memory clearing pass
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("item accepted during clearing pass");

	// display write-back and memory writes never share a cycle
	a_disp: assert property (@(posedge clk) disable iff (!arst_n)
		disp_we |-> !mem_we && $past(state_q) == S_DRD)
		else $error("display write outside sprite row update");
endmodule
